>>> src/assert_macros.svh
// Assertion macros used by the great-circle distance top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Assert that a implies b in the same cycle.
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Assert that a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> src/gcd_pkg.sv
// Package with constants, types and a helper function for the distance pipeline.
package gcd_pkg;

  localparam int AngleFracBits = 20;
  localparam int CordicStages  = 24;
  localparam int DW            = 36;
  localparam logic signed [DW-1:0] CordicKinv = 36'sd652032874;
  localparam logic signed [DW-1:0] OneQ30     = 36'sd1073741824;
  localparam logic [34:0] Deg2RadQ32 = 35'd74961321;
  localparam logic [22:0] DistMax    = 23'h7FFFFF;
  localparam logic [12:0] RadiusReset = 13'd6371;

  // Period constants for the half-difference and latitude folds.
  localparam logic [31:0] HalfPeriod = 32'(180) << (AngleFracBits + 1);
  localparam logic [31:0] LatPeriod  = 32'(360) << AngleFracBits;

  // Q2.30 arctangent of 2^-i.
  function automatic logic signed [DW-1:0] atan_q30(input int i);
    logic signed [DW-1:0] r;
    r = '0;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: begin
        if (i <= 30) r = DW'(64'sd1 <<< (30 - i));
      end
    endcase
    return r;
  endfunction

  typedef enum logic {CORDIC_ROT, CORDIC_VEC} cordic_mode_t;

  // One CORDIC micro-rotation state.
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } cordic_vec_t;

endpackage

>>> src/great_circle_distance.sv
// Great-circle distance top level: fold, CORDIC sin/cos, haversine, roots, atan, scale.
// Throughput: one item per cycle; the pipeline advances whenever the output stage is free.
// Each CORDIC stage and each square-root digit is one register stage.
// Synchronous active-high reset clears all valid bits and sets the radius to 6371 km.
`include "assert_macros.svh"
module great_circle_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [22:0]        distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [12:0]        sphere_radius_km
);

  localparam int DW = gcd_pkg::DW;

  logic en;
  logic [12:0] radius;

  // Whole pipeline moves unless the final result is held.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RadiusReset;
    end else if (cfg_valid) begin
      radius <= sphere_radius_km;
    end
  end

  // ---------------- Stage 1: differences and magnitudes ----------------
  logic        v1;
  logic [31:0] m_dl1, m_do1, m_la1, m_lb1;
  logic signed [29:0] dl, dlo;
  always_comb begin
    dl  = 30'(lat_b) - 30'(lat_a);
    dlo = 30'(lon_b) - 30'(lon_a);
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      m_dl1 <= dl[29]  ? 32'(-dl)  : 32'(dl);
      m_do1 <= dlo[29] ? 32'(-dlo) : 32'(dlo);
      // widen before negating so the most negative latitude keeps its magnitude
      m_la1 <= lat_a[27] ? 32'(-(32'(lat_a))) : 32'(lat_a);
      m_lb1 <= lat_b[27] ? 32'(-(32'(lat_b))) : 32'(lat_b);
    end
  end

  // ---------------- Stages 2..5: modulo by repeated conditional subtract ----------------
  // Magnitudes < 2^30; half period is 2^28*1.4, lat period 2^28*1.4; 4 subtract steps of
  // 8P,4P,2P,P reduce anything below 16P.
  logic        vm [5];
  logic [31:0] mdl [5], mdo [5], mla [5], mlb [5];
  assign vm[0] = v1;
  assign mdl[0] = m_dl1; assign mdo[0] = m_do1;
  assign mla[0] = m_la1; assign mlb[0] = m_lb1;
  for (genvar k = 0; k < 4; k++) begin : g_mod
    localparam logic [35:0] Ph = 36'(gcd_pkg::HalfPeriod) << (3 - k);
    localparam logic [35:0] Pl = 36'(gcd_pkg::LatPeriod) << (3 - k);
    always_ff @(posedge clk) begin
      if (rst) vm[k+1] <= 1'b0;
      else if (en) vm[k+1] <= vm[k];
      if (en) begin
        mdl[k+1] <= (36'(mdl[k]) >= Ph) ? 32'(36'(mdl[k]) - Ph) : mdl[k];
        mdo[k+1] <= (36'(mdo[k]) >= Ph) ? 32'(36'(mdo[k]) - Ph) : mdo[k];
        mla[k+1] <= (36'(mla[k]) >= Pl) ? 32'(36'(mla[k]) - Pl) : mla[k];
        mlb[k+1] <= (36'(mlb[k]) >= Pl) ? 32'(36'(mlb[k]) - Pl) : mlb[k];
      end
    end
  end

  // ---------------- Stage 6: fold ----------------
  logic        v6, nega6, negb6;
  logic [31:0] fdl6, fdo6, fla6, flb6;
  function automatic logic [31:0] fold_lat(input logic [31:0] m, output logic neg);
    logic [31:0] t;
    t = (m > (gcd_pkg::LatPeriod >> 1)) ? gcd_pkg::LatPeriod - m : m;
    neg = t > (gcd_pkg::LatPeriod >> 2);
    return neg ? (gcd_pkg::LatPeriod >> 1) - t : t;
  endfunction
  logic na, nb;
  logic [31:0] fa, fb;
  always_comb begin
    fa = fold_lat(mla[4], na);
    fb = fold_lat(mlb[4], nb);
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= vm[4];
    if (en) begin
      fdl6 <= (mdl[4] > (gcd_pkg::HalfPeriod >> 1)) ? gcd_pkg::HalfPeriod - mdl[4] : mdl[4];
      fdo6 <= (mdo[4] > (gcd_pkg::HalfPeriod >> 1)) ? gcd_pkg::HalfPeriod - mdo[4] : mdo[4];
      fla6 <= fa; flb6 <= fb;
      nega6 <= na; negb6 <= nb;
    end
  end

  // ---------------- Stage 7: to radians (multiply) ----------------
  logic        v7, nega7, negb7;
  logic [62:0] pdl7, pdo7, pla7, plb7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      pdl7 <= 63'(fdl6) * 63'(gcd_pkg::Deg2RadQ32);
      pdo7 <= 63'(fdo6) * 63'(gcd_pkg::Deg2RadQ32);
      pla7 <= 63'(fla6) * 63'(gcd_pkg::Deg2RadQ32);
      plb7 <= 63'(flb6) * 63'(gcd_pkg::Deg2RadQ32);
      nega7 <= nega6; negb7 <= negb6;
    end
  end

  // ---------------- Stage 8: round ----------------
  localparam int ShD = gcd_pkg::AngleFracBits + 3;
  localparam int ShL = gcd_pkg::AngleFracBits + 2;
  logic        v8;
  gcd_pkg::cordic_vec_t cin_dl, cin_do, cin_la, cin_lb;
  logic [62:0] rdl, rdo, rla, rlb;
  always_comb begin
    rdl = (pdl7 + (63'd1 << (ShD - 1))) >> ShD;
    rdo = (pdo7 + (63'd1 << (ShD - 1))) >> ShD;
    rla = (pla7 + (63'd1 << (ShL - 1))) >> ShL;
    rlb = (plb7 + (63'd1 << (ShL - 1))) >> ShL;
  end
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      cin_dl <= '{gcd_pkg::CordicKinv, '0, DW'(rdl)};
      cin_do <= '{gcd_pkg::CordicKinv, '0, DW'(rdo)};
      cin_la <= '{gcd_pkg::CordicKinv, '0, DW'(rla)};
      cin_lb <= '{gcd_pkg::CordicKinv, '0, DW'(rlb)};
    end
  end

  // Cosine sign travels alongside the CORDIC
  logic nsa [gcd_pkg::CordicStages+1];
  logic nsb [gcd_pkg::CordicStages+1];
  always_ff @(posedge clk) begin
    if (en) begin
      nsa[0] <= nega7; nsb[0] <= negb7;
    end
  end
  for (genvar k = 0; k < gcd_pkg::CordicStages; k++) begin : g_ns
    always_ff @(posedge clk) begin
      if (en) begin
        nsa[k+1] <= nsa[k]; nsb[k+1] <= nsb[k];
      end
    end
  end

  // ---------------- Four rotation CORDICs ----------------
  logic vc, vc_u1, vc_u2, vc_u3;
  gcd_pkg::cordic_vec_t o_dl, o_do, o_la, o_lb;
  gcd_cordic u_cdl (.clk, .rst, .en, .in_valid(v8), .mode(gcd_pkg::CORDIC_ROT),
                    .in_v(cin_dl), .out_valid(vc), .out_v(o_dl));
  gcd_cordic u_cdo (.clk, .rst, .en, .in_valid(v8), .mode(gcd_pkg::CORDIC_ROT),
                    .in_v(cin_do), .out_valid(vc_u1), .out_v(o_do));
  gcd_cordic u_cla (.clk, .rst, .en, .in_valid(v8), .mode(gcd_pkg::CORDIC_ROT),
                    .in_v(cin_la), .out_valid(vc_u2), .out_v(o_la));
  gcd_cordic u_clb (.clk, .rst, .en, .in_valid(v8), .mode(gcd_pkg::CORDIC_ROT),
                    .in_v(cin_lb), .out_valid(vc_u3), .out_v(o_lb));

  // ---------------- Stage h1: squares and cos product ----------------
  logic v_h1;
  logic signed [71:0] sq_dl, sq_do, cprod;
  logic signed [DW-1:0] ca, cb;
  always_comb begin
    ca = nsa[gcd_pkg::CordicStages] ? -o_la.x : o_la.x;
    cb = nsb[gcd_pkg::CordicStages] ? -o_lb.x : o_lb.x;
  end
  always_ff @(posedge clk) begin
    if (rst) v_h1 <= 1'b0;
    else if (en) v_h1 <= vc;
    if (en) begin
      sq_dl <= 72'(o_dl.y) * 72'(o_dl.y);
      sq_do <= 72'(o_do.y) * 72'(o_do.y);
      cprod <= 72'(ca) * 72'(cb);
    end
  end

  // ---------------- Stage h2: shift ----------------
  logic v_h2;
  logic signed [DW-1:0] sdl2, sdo2, cc2;
  always_ff @(posedge clk) begin
    if (rst) v_h2 <= 1'b0;
    else if (en) v_h2 <= v_h1;
    if (en) begin
      sdl2 <= DW'(sq_dl >>> 30);
      sdo2 <= DW'(sq_do >>> 30);
      cc2  <= DW'(cprod >>> 30);
    end
  end

  // ---------------- Stage h3: cc * sdo ----------------
  logic v_h3;
  logic signed [71:0] p3;
  logic signed [DW-1:0] sdl3;
  always_ff @(posedge clk) begin
    if (rst) v_h3 <= 1'b0;
    else if (en) v_h3 <= v_h2;
    if (en) begin
      p3 <= 72'(cc2) * 72'(sdo2);
      sdl3 <= sdl2;
    end
  end

  // ---------------- Stage h4: sum and clamp ----------------
  logic v_h4;
  logic [30:0] a4;
  logic signed [DW:0] asum;
  always_comb asum = (DW+1)'(sdl3) + (DW+1)'(p3 >>> 30);
  always_ff @(posedge clk) begin
    if (rst) v_h4 <= 1'b0;
    else if (en) v_h4 <= v_h3;
    if (en) begin
      if (asum < 0) a4 <= '0;
      else if (asum > (DW+1)'(gcd_pkg::OneQ30)) a4 <= 31'(gcd_pkg::OneQ30);
      else a4 <= 31'(asum);
    end
  end

  // ---------------- Stage h5: root operands ----------------
  // a = 1.0 needs the full 61 bits after the shift
  logic v_h5;
  logic [60:0] ra, rb;
  always_ff @(posedge clk) begin
    if (rst) v_h5 <= 1'b0;
    else if (en) v_h5 <= v_h4;
    if (en) begin
      ra <= 61'(a4) << 30;
      rb <= 61'(31'(gcd_pkg::OneQ30) - a4) << 30;
    end
  end

  // ---------------- Square roots ----------------
  logic vs, vs_u;
  logic [30:0] sq_a, sq_b;
  gcd_isqrt u_sqa (.clk, .rst, .en, .in_valid(v_h5), .in_v(ra),
                   .out_valid(vs), .root(sq_a));
  gcd_isqrt u_sqb (.clk, .rst, .en, .in_valid(v_h5), .in_v(rb),
                   .out_valid(vs_u), .root(sq_b));

  // ---------------- Vectoring CORDIC ----------------
  logic vv;
  gcd_pkg::cordic_vec_t vin, vout;
  assign vin = '{DW'(sq_b), DW'(sq_a), '0};
  gcd_cordic u_cvec (.clk, .rst, .en, .in_valid(vs), .mode(gcd_pkg::CORDIC_VEC),
                     .in_v(vin), .out_valid(vv), .out_v(vout));

  // ---------------- Scale by radius ----------------
  logic v_s1;
  logic [48:0] prod_s1;
  logic [DW-2:0] zc;
  always_comb zc = vout.z[DW-1] ? '0 : vout.z[DW-2:0];
  always_ff @(posedge clk) begin
    if (rst) v_s1 <= 1'b0;
    else if (en) v_s1 <= vv;
    if (en) prod_s1 <= 49'(radius) * 49'(zc);
  end

  logic [48:0] dsh;
  always_comb dsh = (prod_s1 + (49'd1 << 20)) >> 21;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_s1;
    if (en) distance <= (dsh > 49'(gcd_pkg::DistMax)) ? gcd_pkg::DistMax : dsh[22:0];
  end

  // ---------------- Checks ----------------
  `ASSERT_IMPL(a_lanes_aligned, clk, rst, vc, vc_u1 && vc_u2 && vc_u3)
  `ASSERT_IMPL(a_roots_aligned, clk, rst, vs, vs_u)
  `ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ready, out_valid && $stable(distance))

endmodule

>>> src/gcd_cordic.sv
// Pipelined CORDIC, one stage per iteration, rotation or vectoring mode.
module gcd_cordic (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  gcd_pkg::cordic_mode_t     mode,
  input  gcd_pkg::cordic_vec_t      in_v,
  output logic                      out_valid,
  output gcd_pkg::cordic_vec_t      out_v
);

  gcd_pkg::cordic_vec_t st [gcd_pkg::CordicStages+1];
  logic vld [gcd_pkg::CordicStages+1];

  assign st[0]  = in_v;
  assign vld[0] = in_valid;

  // One register stage per micro-rotation
  for (genvar i = 0; i < gcd_pkg::CordicStages; i++) begin : g_stage
    logic dir;
    logic signed [gcd_pkg::DW-1:0] xs, ys;
    gcd_pkg::cordic_vec_t nxt;
    always_comb begin
      xs = st[i].x >>> i;
      ys = st[i].y >>> i;
      dir = (mode == gcd_pkg::CORDIC_ROT) ? !st[i].z[gcd_pkg::DW-1] : st[i].y[gcd_pkg::DW-1];
      if (dir) begin
        nxt.x = st[i].x - ys;
        nxt.y = st[i].y + xs;
        nxt.z = (mode == gcd_pkg::CORDIC_ROT) ? st[i].z - gcd_pkg::atan_q30(i)
                                               : st[i].z - gcd_pkg::atan_q30(i);
      end else begin
        nxt.x = st[i].x + ys;
        nxt.y = st[i].y - xs;
        nxt.z = st[i].z + gcd_pkg::atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[gcd_pkg::CordicStages];
  assign out_v     = st[gcd_pkg::CordicStages];

endmodule

>>> src/gcd_isqrt.sv
// Pipelined digit-by-digit integer square root of a 61-bit value, one digit per stage.
module gcd_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [60:0] in_v,
  output logic        out_valid,
  output logic [30:0] root
);

  localparam int Steps = 31;

  logic [61:0] rem [Steps+1];
  logic [61:0] res [Steps+1];
  logic        vld [Steps+1];

  assign rem[0] = {1'b0, in_v};
  assign res[0] = '0;
  assign vld[0] = in_valid;

  // One result bit per stage, bit weight 4^(30-i)
  for (genvar i = 0; i < Steps; i++) begin : g_dig
    localparam logic [61:0] Bit = 62'd1 << (2 * (Steps - 1 - i));
    logic [61:0] rn, qn;
    always_comb begin
      if (rem[i] >= res[i] + Bit) begin
        rn = rem[i] - (res[i] + Bit);
        qn = (res[i] >> 1) + Bit;
      end else begin
        rn = rem[i];
        qn = res[i] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= rn;
        res[i+1] <= qn;
      end
    end
  end

  assign out_valid = vld[Steps];
  assign root      = res[Steps][30:0];

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the great-circle distance pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LatMax   = 94371840;
  localparam int LonMax   = 188743680;
  localparam int RandN    = 600;
  localparam int Latency  = 94;
  localparam int CycLimit = 400000;
  localparam int Kinv     = 652032874;
  localparam longint OneQ = 64'd1073741824;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [27:0] lat_a;
  logic signed [28:0] lon_a;
  logic signed [27:0] lat_b;
  logic signed [28:0] lon_b;
  logic               out_valid;
  logic               out_ready;
  logic [22:0]        distance;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [12:0]        sphere_radius_km;

  great_circle_distance DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_ready(out_ready), .distance(distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .sphere_radius_km(sphere_radius_km)
  );

  // Arithmetic shift right, floor rounding
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_tab(int i);
    longint head [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  // Degrees (fb fraction bits) to Q2.30 radians, rounded half up
  function automatic longint deg_to_rad(longint unsigned m, int fb);
    int sh;
    sh = fb + 2;
    return longint'((m * 64'd74961321 + (64'd1 << (sh - 1))) >> sh);
  endfunction

  // Rotation CORDIC; returns sine and cosine
  function automatic void rotate(longint ang, output longint sn, output longint cs);
    longint x, y, z, nx;
    x = Kinv; y = 0; z = ang;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= arctan_tab(i);
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += arctan_tab(i);
      end
      x = nx;
    end
    sn = y; cs = x;
  endfunction

  // Vectoring CORDIC; returns angle
  function automatic longint arctan2(longint xi, longint yi);
    longint x, y, z, nx;
    x = xi; y = yi; z = 0;
    for (int i = 0; i < 24; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += arctan_tab(i);
      end else begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= arctan_tab(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sin^2 of half a coordinate difference
  function automatic longint half_sin_sq(longint d);
    longint unsigned p, m;
    longint sn, cs;
    p = 64'd180 << 21;
    m = (d < 0) ? longint'(-d) : d;
    m = m % p;
    if (m > p / 2) m = p - m;
    rotate(deg_to_rad(m, 21), sn, cs);
    return shr_floor(sn * sn, 30);
  endfunction

  // Cosine of a latitude, sign kept
  function automatic longint lat_cos(longint lat);
    longint unsigned p, m;
    longint sn, cs;
    bit neg;
    p = 64'd360 << 20;
    m = (lat < 0) ? longint'(-lat) : lat;
    m = m % p;
    if (m > p / 2) m = p - m;
    neg = m > p / 4;
    if (neg) m = p / 2 - m;
    rotate(deg_to_rad(m, 20), sn, cs);
    return neg ? -cs : cs;
  endfunction

  function automatic logic [22:0] haversine_dist(logic [12:0] radius,
      logic signed [27:0] la, logic signed [28:0] oa,
      logic signed [27:0] lb, logic signed [28:0] ob);
    longint sdl, sdo, cc, hav, z;
    longint unsigned d;
    sdl = half_sin_sq(longint'(lb) - longint'(la));
    sdo = half_sin_sq(longint'(ob) - longint'(oa));
    cc  = shr_floor(lat_cos(la) * lat_cos(lb), 30);
    hav = sdl + shr_floor(cc * sdo, 30);
    if (hav < 0) hav = 0;
    if (hav > OneQ) hav = OneQ;
    z = arctan2(longint'(int_sqrt(longint'(OneQ - hav) << 30)),
                longint'(int_sqrt(longint'(hav) << 30)));
    if (z < 0) z = 0;
    d = (longint'(radius) * z + (64'd1 << 20)) >> 21;
    if (d > 64'd8388607) d = 64'd8388607;
    return d[22:0];
  endfunction

  // Queue of expected distances
  class dist_scoreboard;
    logic [22:0] pending[$];
    int errors;
    logic [12:0] radius;

    function new();
      errors = 0;
      radius = 13'd6371;
    endfunction

    function void note_pair(logic signed [27:0] la, logic signed [28:0] oa,
                            logic signed [27:0] lb, logic signed [28:0] ob);
      pending.push_back(haversine_dist(radius, la, oa, lb, ob));
    endfunction

    function void check_distance(logic [22:0] got);
      logic [22:0] exp_d;
      if (pending.size() == 0) begin
        $error("distance: unexpected transfer, actual %0d", got);
        errors++;
        return;
      end
      exp_d = pending.pop_front();
      if (got !== exp_d) begin
        $error("distance: expected %0d actual %0d", exp_d, got);
        errors++;
      end
    endfunction
  endclass

  dist_scoreboard board;
  bit  quiet;
  bit  hold_off;
  int  cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycLimit) begin
      $display("great_circle_distance regression: fail");
      $finish;
    end
  end

  // Output side: check transfers, random stalls
  initial begin
    int stall;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_distance(distance);
      if (hold_off) begin
        out_ready <= 0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Long receiver hold-off, counted here; starts while random items are flowing
  initial begin
    hold_off = 0;
    wait (cycles == 400);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
  end

  task automatic send_pair(logic signed [27:0] la, logic signed [28:0] oa,
                           logic signed [27:0] lb, logic signed [28:0] ob);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    lat_a <= la; lon_a <= oa; lat_b <= lb; lon_b <= ob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pair(la, oa, lb, ob);
  endtask

  task automatic write_radius(logic [12:0] r);
    in_valid <= 0;
    cfg_valid <= 1;
    sphere_radius_km <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    board.radius = r;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  function automatic int rand_field(int lim, int w);
    int v;
    case ($urandom_range(0, 9))
      0: v = lim;
      1: v = -lim;
      2: v = $urandom_range(0, 1) ? (1 << (w - 1)) - 1 : -(1 << (w - 1));
      3: v = $urandom_range(0, 2000) - 1000;
      default: v = int'($urandom_range(0, 2 * lim)) - lim;
    endcase
    return v;
  endfunction

  task automatic random_pairs(int n);
    int la, lb, oa, ob;
    for (int i = 0; i < n; i++) begin
      la = rand_field(LatMax, 28);
      oa = rand_field(LonMax, 29);
      if ($urandom_range(0, 3) == 0) begin
        // nearby points
        lb = la + $urandom_range(0, 4000) - 2000;
        ob = oa + $urandom_range(0, 4000) - 2000;
      end else begin
        lb = rand_field(LatMax, 28);
        ob = rand_field(LonMax, 29);
      end
      send_pair(28'(la), 29'(oa), 28'(lb), 29'(ob));
    end
  endtask

  initial begin
    logic [12:0] radii [4] = '{13'd1, 13'd8191, 13'd0, 13'd6371};
    board = new();
    quiet = 0;
    cycles = 0;
    rst <= 1;
    in_valid <= 0; cfg_valid <= 0;
    lat_a <= 0; lon_a <= 0; lat_b <= 0; lon_b <= 0;
    sphere_radius_km <= 13'd6371;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, identical points, antipodes, out-of-range angles
    send_pair(0, 0, 0, 0);
    send_pair(LatMax, LonMax, -LatMax, -LonMax);
    send_pair(-LatMax, 0, LatMax, 0);
    send_pair(0, -LonMax, 0, LonMax);
    send_pair(0, 0, 0, LonMax);
    send_pair(LatMax, 0, LatMax, LonMax);
    send_pair(28'h7FFFFFF, 29'h0FFFFFFF, 28'h8000000, 29'h10000000);
    send_pair(28'h8000000, 29'h10000000, 28'h7FFFFFF, 29'h0FFFFFFF);
    send_pair(28'h8000000, 29'h10000000, 28'h8000000, 29'h10000000);
    send_pair(1, -1, -1, 1);
    send_pair(28'sd47185920, 29'sd0, -28'sd47185920, 29'sd94371840);
    send_pair(0, 0, 28'h5A00000, 29'h0);
    drain();

    // Each radius setting, extremes included
    foreach (radii[k]) begin
      write_radius(radii[k]);
      send_pair(0, -LonMax, 0, LonMax);
      send_pair(28'h7FFFFFF, 29'h0FFFFFFF, 28'h8000000, 29'h10000000);
      random_pairs(RandN / 5);
      drain();
    end

    // Last part: random radius, no idling
    write_radius(13'($urandom_range(1, 8191)));
    quiet = 1;
    random_pairs(RandN / 5);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("great_circle_distance regression: pass");
    end else begin
      $display("great_circle_distance regression: fail");
    end
    $finish;
  end
endmodule
